// File: sv/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants of the BMP24 stream decoder
// Holds the port payload structs, result and error codes, and the token
// record that travels from the byte parser to the pixel assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

	localparam int unsigned DIM_W = 13;          // width/height store
	localparam int unsigned POS_W = 12;          // column/row index
	localparam logic [31:0] MAX_DIMENSION = 32'd4096;

	// result kinds
	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_HDR_OK  = 2'd1;
	localparam logic [1:0] KIND_HDR_ERR = 2'd2;

	// header error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE = 3'd1;
	localparam logic [2:0] ERR_RESERVED  = 3'd2;
	localparam logic [2:0] ERR_PLANES    = 3'd3;
	localparam logic [2:0] ERR_DEPTH     = 3'd4;
	localparam logic [2:0] ERR_OFFSET    = 3'd5;
	localparam logic [2:0] ERR_SIZE      = 3'd6;

	typedef enum logic [2:0] {
		TOK_HDR_OK,
		TOK_HDR_ERR,
		TOK_BLUE,
		TOK_GREEN,
		TOK_RED
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [2:0]       error_code;
		logic             last_pixel;
	} out_item_t;

	typedef struct packed {
		tok_kind_t        kind;
		logic [7:0]       data;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [2:0]       error_code;
		logic             last;
	} token_t;

endpackage

`default_nettype wire

// File: sv/bsd_front.sv
// ----------------------------------------------------------------------------
// bsd_front: byte parser
// Checks the 54-byte header, tracks pixel byte phase, row padding and the
// column/row counters, and turns each useful byte into a token.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bsd_pkg::in_item_t item,
	input  wire logic              q_full,
	output logic                   tok_wr,
	output bsd_pkg::token_t        tok
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXELS,
		PH_IDLE
	} phase_t;

	localparam logic [5:0] POS_SIGNATURE = 6'd1;
	localparam logic [5:0] POS_RESERVED  = 6'd9;
	localparam logic [5:0] POS_OFFSET    = 6'd13;
	localparam logic [5:0] POS_WIDTH     = 6'd21;
	localparam logic [5:0] POS_HEIGHT    = 6'd25;
	localparam logic [5:0] POS_PLANES    = 6'd27;
	localparam logic [5:0] POS_DEPTH     = 6'd29;
	localparam logic [5:0] POS_LAST      = 6'd53;

	phase_t                       phase_q, phase_d;
	logic [5:0]                   pos_q, pos_d;
	logic [31:0]                  shift_q, shift_d;
	logic [bsd_pkg::DIM_W-1:0]    width_q, width_d;
	logic [bsd_pkg::DIM_W-1:0]    height_q, height_d;
	logic [bsd_pkg::POS_W-1:0]    col_q, col_d;
	logic [bsd_pkg::DIM_W-1:0]    frow_q, frow_d;
	logic [1:0]                   bip_q, bip_d;
	logic [1:0]                   pad_q, pad_d;

	logic                         accept;
	logic                         tok_valid;
	logic [31:0]                  shift_nx;
	logic [15:0]                  half;
	logic                         dim_ok;
	logic [2:0]                   err;
	logic                         row_end;
	logic                         last;
	logic [bsd_pkg::DIM_W:0]      frow_p1;
	logic [bsd_pkg::DIM_W-1:0]    top_row;

	assign accept = push && !q_full;
	assign tok_wr = accept && tok_valid;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		shift_d  = shift_q;
		width_d  = width_q;
		height_d = height_q;
		col_d    = col_q;
		frow_d   = frow_q;
		bip_d    = bip_q;
		pad_d    = pad_q;
		if (item.file_start) begin
			phase_d  = PH_HEADER;
			pos_d    = '0;
			shift_d  = '0;
			width_d  = '0;
			height_d = '0;
			col_d    = '0;
			frow_d   = '0;
			bip_d    = '0;
			pad_d    = '0;
		end

		tok       = '0;
		tok.kind  = bsd_pkg::TOK_BLUE;
		tok_valid = 1'b0;
		err       = bsd_pkg::ERR_NONE;

		shift_nx = {item.data_byte, shift_d[31:8]};
		half     = shift_nx[31:16];
		dim_ok   = (shift_nx != 32'd0) && (shift_nx <= bsd_pkg::MAX_DIMENSION);

		row_end = (({1'b0, col_d} + 13'd1) >= width_d);
		frow_p1 = {1'b0, frow_d} + 14'd1;
		last    = row_end && (frow_p1 >= {1'b0, height_d});
		top_row = height_d - 13'd1 - frow_d;

		case (phase_d)
			PH_HEADER: begin
				shift_d = shift_nx;
				case (pos_d)
					POS_SIGNATURE: if (half != 16'h4D42) err = bsd_pkg::ERR_SIGNATURE;
					POS_RESERVED:  if (shift_nx != 32'd0) err = bsd_pkg::ERR_RESERVED;
					POS_OFFSET:    if (shift_nx != 32'd54) err = bsd_pkg::ERR_OFFSET;
					POS_WIDTH: begin
						if (!dim_ok) err = bsd_pkg::ERR_SIZE;
						else width_d = shift_nx[bsd_pkg::DIM_W-1:0];
					end
					POS_HEIGHT: begin
						if (!dim_ok) err = bsd_pkg::ERR_SIZE;
						else height_d = shift_nx[bsd_pkg::DIM_W-1:0];
					end
					POS_PLANES:    if (half != 16'd1) err = bsd_pkg::ERR_PLANES;
					POS_DEPTH:     if (half != 16'd24) err = bsd_pkg::ERR_DEPTH;
					default: ;
				endcase
				if (err != bsd_pkg::ERR_NONE) begin
					phase_d        = PH_IDLE;
					tok_valid      = 1'b1;
					tok.kind       = bsd_pkg::TOK_HDR_ERR;
					tok.error_code = err;
				end else if (pos_d == POS_LAST) begin
					phase_d   = PH_PIXELS;
					pos_d     = '0;
					tok_valid = 1'b1;
					tok.kind  = bsd_pkg::TOK_HDR_OK;
				end else begin
					pos_d = pos_d + 6'd1;
				end
			end
			PH_PIXELS: begin
				if (pad_d != 2'd0) begin
					pad_d = pad_d - 2'd1;
				end else begin
					case (bip_d)
						2'd0: begin
							tok_valid = 1'b1;
							tok.kind  = bsd_pkg::TOK_BLUE;
							bip_d     = 2'd1;
						end
						2'd1: begin
							tok_valid = 1'b1;
							tok.kind  = bsd_pkg::TOK_GREEN;
							bip_d     = 2'd2;
						end
						default: begin
							tok_valid  = 1'b1;
							tok.kind   = bsd_pkg::TOK_RED;
							tok.column = col_d;
							tok.row    = top_row[bsd_pkg::POS_W-1:0];
							tok.last   = last;
							bip_d      = 2'd0;
							if (row_end) begin
								col_d  = '0;
								pad_d  = width_d[1:0];
								frow_d = frow_p1[bsd_pkg::DIM_W-1:0];
								if (last) phase_d = PH_IDLE;
							end else begin
								col_d = col_d + 12'd1;
							end
						end
					endcase
				end
			end
			default: ;
		endcase

		tok.data   = item.data_byte;
		tok.width  = width_d;
		tok.height = height_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			shift_q  <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			frow_q   <= '0;
			bip_q    <= '0;
			pad_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			shift_q  <= shift_d;
			width_q  <= width_d;
			height_q <= height_d;
			col_q    <= col_d;
			frow_q   <= frow_d;
			bip_q    <= bip_d;
			pad_q    <= pad_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/bsd_tok_queue.sv
// ----------------------------------------------------------------------------
// bsd_tok_queue: two-entry token queue
// Decouples the byte parser from the pixel assembler.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_tok_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire bsd_pkg::token_t wr_data,
	output logic                 full,
	input  wire logic            rd,
	output bsd_pkg::token_t      rd_data,
	output logic                 valid
);

	bsd_pkg::token_t mem_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;

	assign full    = (count_q == 2'd2);
	assign valid   = (count_q != 2'd0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr) wptr_q <= ~wptr_q;
			if (rd) rptr_q <= ~rptr_q;
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/bsd_back.sv
// ----------------------------------------------------------------------------
// bsd_back: pixel assembler and result register
// Collects blue and green bytes, emits pixels on red, forwards header
// results, and holds the oldest result until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire bsd_pkg::token_t q_data,
	output logic                 q_rd,
	output bsd_pkg::out_item_t   result,
	output logic                 empty,
	input  wire logic            pop
);

	logic [7:0]         blue_q;
	logic [7:0]         green_q;
	logic               out_valid_q;
	bsd_pkg::out_item_t out_q;
	bsd_pkg::out_item_t res;
	logic               produces;
	logic               pop_ok;
	logic               room;

	assign pop_ok = pop && out_valid_q;
	assign room   = !out_valid_q || pop_ok;
	assign q_rd   = q_valid && (!produces || room);
	assign empty  = !out_valid_q;
	assign result = out_q;

	always_comb begin
		res              = '0;
		res.image_width  = q_data.width;
		res.image_height = q_data.height;
		produces         = 1'b0;
		case (q_data.kind)
			bsd_pkg::TOK_HDR_OK: begin
				produces        = 1'b1;
				res.result_kind = bsd_pkg::KIND_HDR_OK;
			end
			bsd_pkg::TOK_HDR_ERR: begin
				produces        = 1'b1;
				res.result_kind = bsd_pkg::KIND_HDR_ERR;
				res.error_code  = q_data.error_code;
			end
			bsd_pkg::TOK_RED: begin
				produces        = 1'b1;
				res.result_kind = bsd_pkg::KIND_PIXEL;
				res.red         = q_data.data;
				res.green       = green_q;
				res.blue        = blue_q;
				res.column      = q_data.column;
				res.row         = q_data.row;
				res.last_pixel  = q_data.last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_rd && (q_data.kind == bsd_pkg::TOK_BLUE))  blue_q  <= q_data.data;
		if (q_rd && (q_data.kind == bsd_pkg::TOK_GREEN)) green_q <= q_data.data;
		if (q_rd && produces) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_rd && produces) begin
			out_valid_q <= 1'b1;
		end else if (pop_ok) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: sv/bmp24_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp24_stream_decoder: 24-bit BMP byte stream decoder
// Checks the 54-byte header of an uncompressed 24 bpp bitmap and turns the
// pixel data into RGB pixels with column and top-down row, skipping row pad.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Payload     | Transaction
// --------+--------------------+-------------+--------------------------------
// input   | push / full        | item        | one file byte (+ start flag)
// result  | empty / pop        | result      | pixel, header ok or header error
//
// Flow: one byte per clock while full is low; parser counters update at the edge
// that takes a byte; results reach the ports via the queue and result register.
// Reset: arst_n clears the parser to header position 0 and empties the
// token queue and the result register.
// Stalls: full rises only when the two-entry token queue is full, which
// happens only while a result waits on a low pop.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_stream_decoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire bsd_pkg::in_item_t item,
	output logic                   empty,
	input  wire logic              pop,
	output bsd_pkg::out_item_t     result
);

	// token path between parser and assembler
	logic            tok_wr;
	bsd_pkg::token_t tok;
	logic            q_full;
	logic            q_rd;
	logic            q_valid;
	bsd_pkg::token_t q_data;

	assign full = q_full;

	// front: header checks, pixel byte phase, padding, column/row counters
	bsd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.tok_wr (tok_wr),
		.tok    (tok)
	);

	bsd_tok_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tok_wr),
		.wr_data (tok),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_data),
		.valid   (q_valid)
	);

	// back: assembles B,G,R into a pixel and holds the result for pop
	bsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_rd    (q_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

`default_nettype wire
